// ===== rtl/pcw_pkg.sv =====
// Shared types, register codes and reset values for the power-cycle watchdog.
`default_nettype none

package pcw_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IDX_INCREMENT = 2'd0;
    localparam logic [1:0] CFG_IDX_WARNING   = 2'd1;
    localparam logic [1:0] CFG_IDX_HOLD      = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  INCREMENT_RESET = 8'd30;
    localparam logic [14:0] WARNING_RESET   = 15'd60;
    localparam logic [3:0]  HOLD_RESET      = 4'd5;

    // Unit field value that disarms the countdown.
    localparam logic [6:0] UNIT_DISARM = 7'h7F;
    localparam logic [6:0] UNIT_KEEP   = 7'h00;

    // Request kinds carried in the input tuser.
    localparam logic REQ_STATUS = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef struct packed {
        logic [7:0]  increment;
        logic [14:0] warning;
        logic [3:0]  hold;
    } t_cfg;

    typedef struct packed {
        logic [14:0] remaining;
        logic [14:0] reload_value;
        logic        armed;
        logic        beep;
        logic [3:0]  hold_left;
    } t_state;

    typedef struct packed {
        logic [14:0] remaining_seconds;
        logic        cycling;
        logic        warning;
        logic        armed;
        logic        beep_on;
        logic        power_on;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/pcw_step.sv =====
// Next-state and result logic for one watchdog request.
`default_nettype none

module pcw_step (
    input  var pcw_pkg::t_state  i_state,
    input  var pcw_pkg::t_cfg    i_cfg,
    input  wire logic            i_req_type,
    input  wire logic [7:0]      i_status_byte,
    output pcw_pkg::t_state      o_state,
    output pcw_pkg::t_result     o_result
);
    import pcw_pkg::*;

    logic [6:0]  units;
    logic [14:0] product;
    logic [3:0]  hold_dec;
    logic [3:0]  hold_load;
    t_state      nxt;

    assign units     = i_status_byte[7:1];
    assign product   = {8'd0, units} * {7'd0, i_cfg.increment};
    assign hold_dec  = i_state.hold_left - 4'd1;
    assign hold_load = (i_cfg.hold == 4'd0) ? 4'd1 : i_cfg.hold;

    // State update for a status write or a one-second tick.
    always_comb begin
        nxt = i_state;
        if (i_req_type == REQ_STATUS) begin
            nxt.beep = i_status_byte[0];
            if (units == UNIT_DISARM) begin
                nxt.armed = 1'b0;
            end else if (units != UNIT_KEEP) begin
                nxt.reload_value = product;
                nxt.remaining    = product;
                nxt.armed        = 1'b1;
            end
        end else begin
            if (i_state.hold_left != 4'd0) begin
                nxt.hold_left = hold_dec;
                // End of the hold: power returns and the count reloads.
                if (hold_dec == 4'd0) begin
                    nxt.beep      = 1'b0;
                    nxt.remaining = i_state.reload_value;
                end
            end else if (i_state.remaining != 15'd0) begin
                nxt.remaining = i_state.remaining - 15'd1;
            end
            // Expired while armed: start a power cycle.
            if (nxt.armed && nxt.hold_left == 4'd0 && nxt.remaining == 15'd0) begin
                nxt.hold_left = hold_load;
            end
        end
    end

    assign o_state = nxt;

    // Result fields reflect the state after the request.
    always_comb begin
        o_result.cycling           = (nxt.hold_left != 4'd0);
        o_result.power_on          = (nxt.hold_left == 4'd0);
        o_result.beep_on           = nxt.beep | (nxt.hold_left != 4'd0);
        o_result.armed             = nxt.armed;
        o_result.warning           = nxt.armed & (nxt.remaining < i_cfg.warning);
        o_result.remaining_seconds = nxt.remaining;
    end

endmodule

`default_nettype wire

// ===== rtl/power_cycle_watchdog_core.sv =====
// Top level of the power-cycle watchdog with stream ports and configuration channel.
`default_nettype none

// The watchdog takes one request word per clock cycle and returns one result word
// for each: the word is captured in an input register, and the state update (a
// 7x8-bit multiply for arming and a 15-bit decrement and compare for ticks) runs
// between that register and the result register. While a result word waits, the
// input register takes one more request and then holds off; when the result
// register is drained and refilled in the same cycle, requests keep flowing every
// cycle. Configuration writes are always accepted and take effect on the next
// request.
module power_cycle_watchdog_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] status_byte
    input  wire logic        s_axis_tuser,   // [0] req_type
    // Result stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [0] power_on, [1] beep_on, [2] armed,
                                             // [3] warning, [4] cycling,
                                             // [19:5] remaining_seconds, [23:20] zero
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data
);
    import pcw_pkg::*;

    logic        r_in_valid;
    logic        r_req_type;
    logic [7:0]  r_status_byte;
    logic        r_out_valid;
    t_result     r_result;
    t_state      r_state;
    t_cfg        r_cfg;
    t_cfg        n_cfg;
    t_state      n_state;
    t_result     n_result;
    logic        advance;

    // The result register can take a new word when empty or being drained.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    // Configuration register decode.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IDX_INCREMENT: n_cfg.increment = i_cfg_data[7:0];
                CFG_IDX_WARNING:   n_cfg.warning   = i_cfg_data;
                CFG_IDX_HOLD:      n_cfg.hold      = i_cfg_data[3:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.increment <= INCREMENT_RESET;
            r_cfg.warning   <= WARNING_RESET;
            r_cfg.hold      <= HOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req_type    <= s_axis_tuser;
            r_status_byte <= s_axis_tdata;
        end
    end

    pcw_step u_step (
        .i_state       (r_state),
        .i_cfg         (r_cfg),
        .i_req_type    (r_req_type),
        .i_status_byte (r_status_byte),
        .o_state       (n_state),
        .o_result      (n_result)
    );

    // Watchdog state commits when the request moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (r_in_valid && advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result};

    // A held request is not dropped while the result register is full.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("request lost while stalled");

    // State changes only when a request is processed.
    a_state_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && advance) |=> $stable(r_state))
        else $error("state changed without a request");

    // A new result appears only from a processed request.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result without a request");

    // Warning is never shown while disarmed.
    a_warn_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_result.armed || !r_result.warning))
        else $error("warning while disarmed");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the power-cycle watchdog core with predicted result words.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcw_pkg::*;

    localparam int         HALF_PERIOD     = 10;
    localparam int         RESET_CYCLES    = 6;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         DRAIN_CYCLES    = 4;
    localparam logic [1:0] CFG_IDX_UNUSED  = 2'd3;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // [7:0] status_byte
    logic        s_axis_tuser  = REQ_STATUS;   // [0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;   // [0] power_on, [1] beep_on, [2] armed, [3] warning,
                                 // [4] cycling, [19:5] remaining_seconds, [23:20] zero
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [14:0] i_cfg_data    = '0;

    // Predicted watchdog settings and state.
    t_cfg    model_cfg   = '{increment: INCREMENT_RESET, warning: WARNING_RESET,
                             hold: HOLD_RESET};
    t_state  model_state = '0;
    t_result expected_results[$];

    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned hold_words_seen = 0;
    int unsigned error_count     = 0;

    // Sender and receiver pacing.
    logic        gaps_on     = 1'b1;
    int unsigned burst_left  = 0;
    event        hold_off_ev;
    logic        rx_hold     = 1'b0;
    t_stall      stall_mode  = STALL_NONE;
    logic [3:0]  stall_phase = '0;

    power_cycle_watchdog_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Apply one request to the predicted state and return the word it should produce.
    function automatic t_result watchdog_advance(input logic req, input logic [7:0] sb);
        t_result    res;
        logic [6:0] units;
        logic       cyc;
        if (req == REQ_STATUS) begin
            units = sb[7:1];
            model_state.beep = sb[0];
            if (units == UNIT_DISARM) begin
                model_state.armed = 1'b0;
            end else if (units != UNIT_KEEP) begin
                model_state.reload_value = 15'(16'(units) * 16'(model_cfg.increment));
                model_state.remaining    = model_state.reload_value;
                model_state.armed        = 1'b1;
            end
        end else begin
            // A running hold counts down first; its end restores power and reloads.
            if (model_state.hold_left != 4'd0) begin
                model_state.hold_left--;
                if (model_state.hold_left == 4'd0) begin
                    model_state.beep      = 1'b0;
                    model_state.remaining = model_state.reload_value;
                end
            end else if (model_state.remaining != 15'd0) begin
                model_state.remaining--;
            end
            // Expiry while armed starts a hold; a zero hold setting counts as one tick.
            if (model_state.armed && model_state.hold_left == 4'd0
                    && model_state.remaining == 15'd0) begin
                model_state.hold_left = (model_cfg.hold == 4'd0) ? 4'd1 : model_cfg.hold;
            end
        end
        cyc = (model_state.hold_left != 4'd0);
        res.power_on          = !cyc;
        res.beep_on           = model_state.beep || cyc;
        res.armed             = model_state.armed;
        res.warning           = model_state.armed
                                && (model_state.remaining < model_cfg.warning);
        res.cycling           = cyc;
        res.remaining_seconds = model_state.remaining;
        return res;
    endfunction

    // Offer one request word, with random bursts and gaps, and record its prediction.
    task automatic push_request(input logic req, input logic [7:0] sb);
        int unsigned gap;
        t_result     res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sb;
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        res = watchdog_advance(req, sb);
        if (res.cycling) hold_words_seen++;
        expected_results.push_back(res);
        items_sent++;
    endtask

    // Write one register; the caller lowers valid after the last write.
    task automatic write_register(input logic [1:0] idx, input logic [14:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IDX_INCREMENT: model_cfg.increment = data[7:0];
            CFG_IDX_WARNING:   model_cfg.warning   = data;
            CFG_IDX_HOLD:      model_cfg.hold      = data[3:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Program all registers; unused upper data bits carry noise.
    task automatic configure(input logic [7:0] inc, input logic [14:0] warn,
                             input logic [3:0] hold);
        if ($urandom_range(0, 1) == 1) write_register(CFG_IDX_UNUSED, 15'($urandom));
        write_register(CFG_IDX_INCREMENT, {7'($urandom), inc});
        write_register(CFG_IDX_WARNING, warn);
        write_register(CFG_IDX_HOLD, {11'($urandom), hold});
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering requests and wait until every predicted word has come back.
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Arm with a small count, then mostly ticks with some stray status writes.
    task automatic run_watchdog_sequence();
        int unsigned units;
        int unsigned span;
        units = $urandom_range(1, 4);
        push_request(REQ_STATUS, {7'(units), 1'($urandom)});
        span = units * model_cfg.increment + model_cfg.hold + 3;
        if (span > 40) span = 40;
        repeat ($urandom_range(1, span)) begin
            if ($urandom_range(0, 9) != 0) begin
                push_request(REQ_TICK, 8'($urandom));
            end else begin
                case ($urandom_range(0, 2))
                    0: push_request(REQ_STATUS, {UNIT_KEEP, 1'($urandom)});
                    1: push_request(REQ_STATUS, {UNIT_DISARM, 1'($urandom)});
                    default: push_request(REQ_STATUS, 8'($urandom));
                endcase
            end
        end
    endtask

    // Reset settings: idle ticks, keep and beep-only bytes, arming, disarming.
    task automatic test_power_up_defaults();
        push_request(REQ_TICK, 8'hA5);
        push_request(REQ_STATUS, {UNIT_KEEP, 1'b0});
        push_request(REQ_STATUS, {UNIT_KEEP, 1'b1});
        push_request(REQ_STATUS, {7'd2, 1'b0});
        push_request(REQ_TICK, 8'h5A);
        push_request(REQ_STATUS, {7'd126, 1'b1});
        push_request(REQ_STATUS, {UNIT_DISARM, 1'b1});
        push_request(REQ_TICK, 8'hFF);
        push_request(REQ_STATUS, {UNIT_DISARM, 1'b0});
    endtask

    // Expiry, a status write in the middle of the hold, then reload and expiry again.
    task automatic test_expiry_and_reload();
        wait_until_drained();
        configure(8'd1, 15'd3, 4'd2);
        push_request(REQ_STATUS, {7'd2, 1'b0});
        repeat (3) push_request(REQ_TICK, 8'h00);
        push_request(REQ_STATUS, {7'd3, 1'b1});
        repeat (4) push_request(REQ_TICK, 8'h00);
    endtask

    // Zero increment keeps the block cycling; zero hold behaves as one tick.
    task automatic test_out_of_range_settings();
        wait_until_drained();
        configure(8'd0, 15'd5, 4'd0);
        push_request(REQ_STATUS, {7'd5, 1'b1});
        repeat (3) push_request(REQ_TICK, 8'h3C);
        push_request(REQ_STATUS, {UNIT_DISARM, 1'b0});
        repeat (2) push_request(REQ_TICK, 8'hC3);
    endtask

    // Largest and smallest legal register values.
    task automatic test_register_extremes();
        wait_until_drained();
        configure(8'd255, 15'd32767, 4'd15);
        push_request(REQ_STATUS, {7'd126, 1'b0});
        push_request(REQ_TICK, 8'h00);
        wait_until_drained();
        configure(8'd1, 15'd0, 4'd1);
        push_request(REQ_STATUS, {7'd1, 1'b0});
        repeat (2) push_request(REQ_TICK, 8'h00);
    endtask

    // Random phases, each with its own settings, stall pattern and sender pacing.
    task automatic test_random_operation();
        int unsigned phase_end;
        for (int phase = 0; phase < 7; phase++) begin
            wait_until_drained();
            case (phase)
                0: configure(8'd1, 15'd0, 4'd1);
                1: configure(8'd255, 15'd32767, 4'd15);
                2: configure(8'd0, 15'($urandom_range(0, 4)), 4'd0);
                default: configure(8'($urandom_range(1, 6)), 15'($urandom_range(0, 40)),
                                   4'($urandom_range(0, 15)));
            endcase
            stall_mode <= t_stall'(phase % 4);
            gaps_on = (phase % 3 != 2);
            phase_end = items_sent + 100;
            while (items_sent < phase_end) run_watchdog_sequence();
        end
    endtask

    // Long receiver hold-off so the core fills and stalls its input, then a full pause.
    task automatic test_output_backpressure();
        wait_until_drained();
        configure(8'd2, 15'd5, 4'd3);
        stall_mode <= STALL_NONE;
        gaps_on = 1'b0;
        -> hold_off_ev;
        repeat (4) run_watchdog_sequence();
        wait_until_drained();
        stall_mode <= STALL_RANDOM;
        gaps_on = 1'b1;
        repeat (4) run_watchdog_sequence();
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, seen);
            error_count++;
        end
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = t_result'(m_axis_tdata[19:0]);
            if (expected_results.size() == 0) begin
                $error("result word %h arrived with nothing predicted", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("power_on", want.power_on, seen.power_on);
                compare_field("beep_on", want.beep_on, seen.beep_on);
                compare_field("armed", want.armed, seen.armed);
                compare_field("warning", want.warning, seen.warning);
                compare_field("cycling", want.cycling, seen.cycling);
                compare_field("remaining_seconds", want.remaining_seconds,
                              seen.remaining_seconds);
                compare_field("padding", 0, m_axis_tdata[23:20]);
                results_checked++;
            end
        end
    end

    // Receiver ready pattern, overridden by the long hold-off.
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (!i_rst_n || rx_hold) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                STALL_NONE:     m_axis_tready <= 1'b1;
                STALL_RANDOM:   m_axis_tready <= ($urandom_range(0, 99) < 65);
                STALL_PERIODIC: m_axis_tready <= (stall_phase < 4'd11);
                default:        m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Long receiver hold-off, counted here in clock cycles.
    initial forever begin
        @(hold_off_ev);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_power_up_defaults();
        test_expiry_and_reload();
        test_out_of_range_settings();
        test_register_extremes();
        test_random_operation();
        test_output_backpressure();
        wait_until_drained();
        $display("Run covered %0d requests, %0d result words and %0d register writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Settings ranged over reset, extreme and out-of-range values; %0d words %s",
                 hold_words_seen, "fell inside a power-off hold.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== power_cycle_watchdog_core.f =====
rtl/pcw_pkg.sv
rtl/pcw_step.sv
rtl/power_cycle_watchdog_core.sv
sim/tb_top.sv
